[rtl/wsef_pkg.sv]
// Shared constants, types and tables for the wavelet subband energy block.
package wsef_pkg;

  // Frame geometry
  localparam int IMAGE_SIDE = 32;
  localparam int COORD_W    = $clog2(IMAGE_SIDE);

  // Region bounds, one bit wider than a coordinate so 2*B1 fits
  localparam logic [COORD_W:0] SIDE_B1   = (COORD_W + 1)'(IMAGE_SIDE / 2);
  localparam logic [COORD_W:0] SIDE_B2   = (COORD_W + 1)'(IMAGE_SIDE / 4);
  localparam logic [COORD_W:0] SIDE_B3   = (COORD_W + 1)'(IMAGE_SIDE / 8);
  localparam logic [COORD_W:0] SIDE_B1X2 = (COORD_W + 1)'(2 * (IMAGE_SIDE / 2));
  localparam logic [COORD_W:0] SIDE_B2X2 = (COORD_W + 1)'(2 * (IMAGE_SIDE / 4));
  localparam logic [COORD_W:0] SIDE_B3X2 = (COORD_W + 1)'(2 * (IMAGE_SIDE / 8));
  localparam logic [COORD_W-1:0] SIDE_LAST = COORD_W'(IMAGE_SIDE - 1);

  // Datapath widths
  localparam int COEF_W  = 24;
  localparam int SHARE_W = 23;
  localparam int SQ_W    = 2 * COEF_W - 1;
  localparam int SUM_W   = SQ_W - 1 + $clog2(IMAGE_SIDE * IMAGE_SIDE + 1);

  // Share scaling: 100 * 2^16 = 25 * 2^18
  localparam int QUO_W       = SHARE_W;
  localparam int STEP_W      = $clog2(QUO_W);
  localparam int SCALE_MUL   = 25;
  localparam int MUL_W       = 5;
  localparam int SCALE_SHIFT = 18;
  localparam int PRE_SHIFT   = QUO_W - SCALE_SHIFT;
  localparam int S25_W       = SUM_W + MUL_W;
  localparam logic [SHARE_W-1:0] SHARE_MAX = SHARE_W'(SCALE_MUL * (1 << SCALE_SHIFT));

  // Energy sum indexes
  localparam int N_SUMS = 11;
  localparam int SIDX_W = $clog2(N_SUMS);
  localparam logic [SIDX_W-1:0] S_H1 = SIDX_W'(0);
  localparam logic [SIDX_W-1:0] S_H2 = SIDX_W'(1);
  localparam logic [SIDX_W-1:0] S_H3 = SIDX_W'(2);
  localparam logic [SIDX_W-1:0] S_V1 = SIDX_W'(3);
  localparam logic [SIDX_W-1:0] S_V2 = SIDX_W'(4);
  localparam logic [SIDX_W-1:0] S_V3 = SIDX_W'(5);
  localparam logic [SIDX_W-1:0] S_D1 = SIDX_W'(6);
  localparam logic [SIDX_W-1:0] S_D2 = SIDX_W'(7);
  localparam logic [SIDX_W-1:0] S_D3 = SIDX_W'(8);
  localparam logic [SIDX_W-1:0] S_A1 = SIDX_W'(9);
  localparam logic [SIDX_W-1:0] S_A3 = SIDX_W'(10);

  // Output share order
  localparam int N_SHARES = 10;
  localparam int IDX_W    = $clog2(N_SHARES);
  localparam logic [SIDX_W-1:0] OUT_ORDER [N_SHARES] = '{
    S_A3, S_H1, S_H2, S_H3, S_V1, S_V2, S_V3, S_D1, S_D2, S_D3
  };
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(N_SHARES - 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QUO_W - 1);

  typedef enum logic [2:0] {
    ST_RUN,
    ST_DRAIN,
    ST_WAIT,
    ST_LOAD,
    ST_DIV,
    ST_WRITE
  } ctrl_state_e;

  typedef struct packed {
    logic             accept;
    logic             load;
    logic             step;
    logic             write;
    logic             clear;
    logic [IDX_W-1:0] share_idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_pixel;
  } dp_status_t;

endpackage

[rtl/wsef_ctrl.sv]
// Sequencer: frame accumulate, drain, then ten shift-subtract divisions.
module wsef_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  wsef_pkg::dp_status_t  status_i,
  output wsef_pkg::ctrl_cmd_t   cmd_o
);

  wsef_pkg::ctrl_state_e              state_q, state_d;
  logic [wsef_pkg::IDX_W-1:0]         idx_q, idx_d;
  logic [wsef_pkg::STEP_W-1:0]        step_q, step_d;
  logic                               out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wsef_pkg::ST_RUN;
      idx_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    step_d        = step_q;
    out_valid_d   = out_valid_q && out_stall_i;
    cmd_o         = '0;
    cmd_o.share_idx = idx_q;
    unique case (state_q)
      wsef_pkg::ST_RUN: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i && status_i.last_pixel) begin
          state_d = wsef_pkg::ST_DRAIN;
        end
      end
      wsef_pkg::ST_DRAIN: begin
        // last square lands in the sums this cycle
        state_d = wsef_pkg::ST_WAIT;
      end
      wsef_pkg::ST_WAIT: begin
        if (!out_valid_q) begin
          idx_d   = '0;
          state_d = wsef_pkg::ST_LOAD;
        end
      end
      wsef_pkg::ST_LOAD: begin
        cmd_o.load = 1'b1;
        step_d     = '0;
        state_d    = wsef_pkg::ST_DIV;
      end
      wsef_pkg::ST_DIV: begin
        cmd_o.step = 1'b1;
        step_d     = step_q + wsef_pkg::STEP_W'(1);
        if (step_q == wsef_pkg::STEP_LAST) begin
          state_d = wsef_pkg::ST_WRITE;
        end
      end
      wsef_pkg::ST_WRITE: begin
        cmd_o.write = 1'b1;
        if (idx_q == wsef_pkg::IDX_LAST) begin
          cmd_o.clear = 1'b1;
          out_valid_d = 1'b1;
          state_d     = wsef_pkg::ST_RUN;
        end else begin
          idx_d   = idx_q + wsef_pkg::IDX_W'(1);
          state_d = wsef_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = wsef_pkg::ST_RUN;
      end
    endcase
  end

  assign in_stall_o  = (state_q != wsef_pkg::ST_RUN);
  assign out_valid_o = out_valid_q;

endmodule

[rtl/wsef_datapath.sv]
// Position counters, square stage, subband accumulators and share divider.
module wsef_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [wsef_pkg::COEF_W-1:0]  coefficient_i,
  input  wsef_pkg::ctrl_cmd_t                 cmd_i,
  output wsef_pkg::dp_status_t                status_o,
  output logic [wsef_pkg::SHARE_W-1:0]        share_o [wsef_pkg::N_SHARES],
  output logic                                zero_energy_o
);

  // {horizontal, vertical, diagonal} membership for one level
  function automatic logic [2:0] level_hit(
    input logic [wsef_pkg::COORD_W:0] row,
    input logic [wsef_pkg::COORD_W:0] col,
    input logic [wsef_pkg::COORD_W:0] bk,
    input logic [wsef_pkg::COORD_W:0] bk2
  );
    logic r_lo, r_hi, c_lo, c_hi;
    r_lo = row < bk;
    r_hi = (row >= bk) && (row < bk2);
    c_lo = col < bk;
    c_hi = (col >= bk) && (col < bk2);
    return {r_hi && c_lo, r_lo && c_hi, r_hi && c_hi};
  endfunction

  logic [wsef_pkg::COORD_W-1:0]   row_q, row_d, col_q, col_d;
  logic [wsef_pkg::COEF_W-1:0]    mag;
  logic [2*wsef_pkg::COEF_W-1:0]  sq_full;
  logic [wsef_pkg::SQ_W-1:0]      sq_q;
  logic [wsef_pkg::COORD_W-1:0]   sq_row_q, sq_col_q;
  logic                           sq_vld_q;

  logic [wsef_pkg::SUM_W-1:0]     sums_q [wsef_pkg::N_SUMS];
  logic [wsef_pkg::SUM_W-1:0]     sums_d [wsef_pkg::N_SUMS];
  logic [wsef_pkg::SUM_W-1:0]     total_q, total_d;
  logic [wsef_pkg::SUM_W-1:0]     sq_ext;
  logic [wsef_pkg::COORD_W:0]     r_x, c_x;
  logic [2:0]                     hit1, hit2, hit3;
  logic                           a1, a3;

  logic [wsef_pkg::SUM_W-1:0]     rem_q, rem_d;
  logic [wsef_pkg::QUO_W-1:0]     feed_q, feed_d, quo_q, quo_d;
  logic [wsef_pkg::S25_W-1:0]     s25;
  logic [wsef_pkg::SUM_W:0]       r2, diff;
  logic                           ge;
  logic                           total_zero;

  logic [wsef_pkg::SHARE_W-1:0]   share_q [wsef_pkg::N_SHARES];
  logic                           zero_q;

  // raster position
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cmd_i.accept) begin
      if (col_q == wsef_pkg::SIDE_LAST) begin
        col_d = '0;
        row_d = (row_q == wsef_pkg::SIDE_LAST) ? '0 : row_q + wsef_pkg::COORD_W'(1);
      end else begin
        col_d = col_q + wsef_pkg::COORD_W'(1);
      end
    end
  end

  assign status_o.last_pixel = (row_q == wsef_pkg::SIDE_LAST) &&
                               (col_q == wsef_pkg::SIDE_LAST);

  // magnitude and square
  assign mag     = coefficient_i[wsef_pkg::COEF_W-1] ? (~coefficient_i + 1'b1) : coefficient_i;
  assign sq_full = mag * mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q    <= '0;
      col_q    <= '0;
      sq_vld_q <= 1'b0;
    end else begin
      row_q    <= row_d;
      col_q    <= col_d;
      sq_vld_q <= cmd_i.accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sq_q     <= sq_full[wsef_pkg::SQ_W-1:0];
      sq_row_q <= row_q;
      sq_col_q <= col_q;
    end
  end

  // accumulate
  always_comb begin
    r_x    = {1'b0, sq_row_q};
    c_x    = {1'b0, sq_col_q};
    sq_ext = wsef_pkg::SUM_W'(sq_q);
    hit1   = level_hit(r_x, c_x, wsef_pkg::SIDE_B1, wsef_pkg::SIDE_B1X2);
    hit2   = level_hit(r_x, c_x, wsef_pkg::SIDE_B2, wsef_pkg::SIDE_B2X2);
    hit3   = level_hit(r_x, c_x, wsef_pkg::SIDE_B3, wsef_pkg::SIDE_B3X2);
    a1     = (r_x < wsef_pkg::SIDE_B1) && (c_x < wsef_pkg::SIDE_B1);
    a3     = (r_x < wsef_pkg::SIDE_B3) && (c_x < wsef_pkg::SIDE_B3);
    sums_d  = sums_q;
    total_d = total_q;
    if (cmd_i.clear) begin
      for (int i = 0; i < wsef_pkg::N_SUMS; i++) begin
        sums_d[i] = '0;
      end
      total_d = '0;
    end else if (sq_vld_q) begin
      if (hit1[2]) sums_d[wsef_pkg::S_H1] = sums_q[wsef_pkg::S_H1] + sq_ext;
      if (hit1[1]) sums_d[wsef_pkg::S_V1] = sums_q[wsef_pkg::S_V1] + sq_ext;
      if (hit1[0]) sums_d[wsef_pkg::S_D1] = sums_q[wsef_pkg::S_D1] + sq_ext;
      if (hit2[2]) sums_d[wsef_pkg::S_H2] = sums_q[wsef_pkg::S_H2] + sq_ext;
      if (hit2[1]) sums_d[wsef_pkg::S_V2] = sums_q[wsef_pkg::S_V2] + sq_ext;
      if (hit2[0]) sums_d[wsef_pkg::S_D2] = sums_q[wsef_pkg::S_D2] + sq_ext;
      if (hit3[2]) sums_d[wsef_pkg::S_H3] = sums_q[wsef_pkg::S_H3] + sq_ext;
      if (hit3[1]) sums_d[wsef_pkg::S_V3] = sums_q[wsef_pkg::S_V3] + sq_ext;
      if (hit3[0]) sums_d[wsef_pkg::S_D3] = sums_q[wsef_pkg::S_D3] + sq_ext;
      if (a1)      sums_d[wsef_pkg::S_A1] = sums_q[wsef_pkg::S_A1] + sq_ext;
      if (a3)      sums_d[wsef_pkg::S_A3] = sums_q[wsef_pkg::S_A3] + sq_ext;
      // total = H1 + V1 + D1 + A1, kept as its own running sum
      if ((|hit1) || a1) total_d = total_q + sq_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < wsef_pkg::N_SUMS; i++) begin
        sums_q[i] <= '0;
      end
      total_q <= '0;
    end else begin
      sums_q  <= sums_d;
      total_q <= total_d;
    end
  end

  // restoring divider: floor(sum * 25 * 2^18 / total), one quotient bit per step
  assign s25        = wsef_pkg::S25_W'(sums_q[wsef_pkg::OUT_ORDER[cmd_i.share_idx]]) *
                      wsef_pkg::S25_W'(wsef_pkg::SCALE_MUL);
  assign r2         = {rem_q, feed_q[wsef_pkg::QUO_W-1]};
  assign diff       = r2 - {1'b0, total_q};
  assign ge         = (r2 >= {1'b0, total_q});
  assign total_zero = (total_q == '0);

  always_comb begin
    rem_d  = rem_q;
    feed_d = feed_q;
    quo_d  = quo_q;
    if (cmd_i.load) begin
      rem_d  = s25[wsef_pkg::PRE_SHIFT +: wsef_pkg::SUM_W];
      feed_d = {s25[wsef_pkg::PRE_SHIFT-1:0], {wsef_pkg::SCALE_SHIFT{1'b0}}};
      quo_d  = '0;
    end else if (cmd_i.step) begin
      rem_d  = ge ? diff[wsef_pkg::SUM_W-1:0] : r2[wsef_pkg::SUM_W-1:0];
      feed_d = {feed_q[wsef_pkg::QUO_W-2:0], 1'b0};
      quo_d  = {quo_q[wsef_pkg::QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    feed_q <= feed_d;
    quo_q  <= quo_d;
    for (int i = 0; i < wsef_pkg::N_SHARES; i++) begin
      if (cmd_i.write && (cmd_i.share_idx == wsef_pkg::IDX_W'(i))) begin
        share_q[i] <= total_zero ? '0 : quo_q;
      end
    end
    if (cmd_i.write) begin
      zero_q <= total_zero;
    end
  end

  assign share_o       = share_q;
  assign zero_energy_o = zero_q;

endmodule

[rtl/wavelet_subband_energy_features_top.sv]
// Top level of the wavelet subband energy share block.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-----------------------------------
//   in      | sink      | in_valid_i / in_stall_o  | coefficient_i (Q15.8, raster order)
//   out     | source    | out_valid_o / out_stall_i| ten Q7.16 shares, zero_energy_o
//
// The input takes one coefficient word per cycle while a frame streams in. After
// the last word of a frame (IMAGE_SIDE^2 words) the input stalls through a drain
// state, a state checking the output register, then ten divisions (load, 23
// shift-subtract steps, write) on the one shared restoring divider. If the
// previous result is still held at the output, the divide phase waits for it
// to be taken.
// Reset clears position, sums and the output valid. A stalled result holds; the
// next frame streams in meanwhile.
module wavelet_subband_energy_features_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [wsef_pkg::COEF_W-1:0]  coefficient_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [wsef_pkg::SHARE_W-1:0]        approx_l3_share_o,
  output logic [wsef_pkg::SHARE_W-1:0]        horiz_l1_share_o,
  output logic [wsef_pkg::SHARE_W-1:0]        horiz_l2_share_o,
  output logic [wsef_pkg::SHARE_W-1:0]        horiz_l3_share_o,
  output logic [wsef_pkg::SHARE_W-1:0]        vert_l1_share_o,
  output logic [wsef_pkg::SHARE_W-1:0]        vert_l2_share_o,
  output logic [wsef_pkg::SHARE_W-1:0]        vert_l3_share_o,
  output logic [wsef_pkg::SHARE_W-1:0]        diag_l1_share_o,
  output logic [wsef_pkg::SHARE_W-1:0]        diag_l2_share_o,
  output logic [wsef_pkg::SHARE_W-1:0]        diag_l3_share_o,
  output logic                                zero_energy_o
);

  wsef_pkg::ctrl_cmd_t           cmd;
  wsef_pkg::dp_status_t          status;
  logic [wsef_pkg::SHARE_W-1:0]  share [wsef_pkg::N_SHARES];

  // sequencer: owns the handshakes and steps the divider
  wsef_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: square stage, eleven subband sums plus total, divider, result words
  wsef_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .coefficient_i (coefficient_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .share_o       (share),
    .zero_energy_o (zero_energy_o)
  );

  // share order: approx 3, H1..H3, V1..V3, D1..D3
  assign approx_l3_share_o = share[0];
  assign horiz_l1_share_o  = share[1];
  assign horiz_l2_share_o  = share[2];
  assign horiz_l3_share_o  = share[3];
  assign vert_l1_share_o   = share[4];
  assign vert_l2_share_o   = share[5];
  assign vert_l3_share_o   = share[6];
  assign diag_l1_share_o   = share[7];
  assign diag_l2_share_o   = share[8];
  assign diag_l3_share_o   = share[9];

endmodule

[rtl/wsef_checker.sv]
// Port-level assertions for the wavelet subband energy block, with bind.
module wsef_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [wsef_pkg::SHARE_W-1:0]        approx_l3_share_o,
  input logic [wsef_pkg::SHARE_W-1:0]        horiz_l1_share_o,
  input logic [wsef_pkg::SHARE_W-1:0]        horiz_l2_share_o,
  input logic [wsef_pkg::SHARE_W-1:0]        horiz_l3_share_o,
  input logic [wsef_pkg::SHARE_W-1:0]        vert_l1_share_o,
  input logic [wsef_pkg::SHARE_W-1:0]        vert_l2_share_o,
  input logic [wsef_pkg::SHARE_W-1:0]        vert_l3_share_o,
  input logic [wsef_pkg::SHARE_W-1:0]        diag_l1_share_o,
  input logic [wsef_pkg::SHARE_W-1:0]        diag_l2_share_o,
  input logic [wsef_pkg::SHARE_W-1:0]        diag_l3_share_o,
  input logic                                zero_energy_o
);

  logic all_zero;
  logic in_range;

  assign all_zero = ~|{approx_l3_share_o, horiz_l1_share_o, horiz_l2_share_o,
                       horiz_l3_share_o, vert_l1_share_o, vert_l2_share_o,
                       vert_l3_share_o, diag_l1_share_o, diag_l2_share_o,
                       diag_l3_share_o};

  assign in_range = (approx_l3_share_o <= wsef_pkg::SHARE_MAX) &&
                    (horiz_l1_share_o  <= wsef_pkg::SHARE_MAX) &&
                    (horiz_l2_share_o  <= wsef_pkg::SHARE_MAX) &&
                    (horiz_l3_share_o  <= wsef_pkg::SHARE_MAX) &&
                    (vert_l1_share_o   <= wsef_pkg::SHARE_MAX) &&
                    (vert_l2_share_o   <= wsef_pkg::SHARE_MAX) &&
                    (vert_l3_share_o   <= wsef_pkg::SHARE_MAX) &&
                    (diag_l1_share_o   <= wsef_pkg::SHARE_MAX) &&
                    (diag_l2_share_o   <= wsef_pkg::SHARE_MAX) &&
                    (diag_l3_share_o   <= wsef_pkg::SHARE_MAX);

  // a held result stays valid; approx 3 and D3 shares and the zero flag stay put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(approx_l3_share_o) &&
      $stable(diag_l3_share_o) && $stable(zero_energy_o))
    else $error("result word changed while stalled");

  // zero total forces every share to zero
  a_zero_forces: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_energy_o |-> all_zero)
    else $error("zero energy result with nonzero share");

  // no share exceeds 100 percent
  a_share_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_range)
    else $error("share above 100 percent");

  // a result is produced only at the end of the frame-end stall
  a_result_after_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared outside frame-end processing");

  // input stall starts only right after an accepted word
  a_stall_after_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i))
    else $error("input stall began without a closing word");

endmodule

bind wavelet_subband_energy_features_top wsef_checker u_checker (.*);
